### design/dlus_pkg.sv
`default_nettype none

package dlus_pkg;

    // Sequence states, numbered densely
    typedef enum logic [4:0] {
        ST_IDLE      = 5'd0,
        ST_CARD      = 5'd1,
        ST_MOUNT     = 5'd2,
        ST_OPEN      = 5'd3,
        ST_HEADER    = 5'd4,
        ST_CLOSEWAIT = 5'd5,
        ST_READ      = 5'd6,
        ST_FCLOSE    = 5'd7,
        ST_LOADED    = 5'd8,
        ST_WOPEN     = 5'd9,
        ST_WHEADER   = 5'd10,
        ST_WDATA     = 5'd11,
        ST_WCLOSE    = 5'd12,
        ST_OPENWAIT  = 5'd13,
        ST_LERR      = 5'd14,
        ST_LON       = 5'd15,
        ST_LOFF      = 5'd16,
        ST_QOPEN     = 5'd17,
        ST_UERR      = 5'd18,
        ST_UON       = 5'd19,
        ST_UOFF      = 5'd20,
        ST_QCLOSE    = 5'd21
    } state_t;

    // Message codes
    typedef enum logic [4:0] {
        MSG_NONE          = 5'd0,
        MSG_CARD_FOUND    = 5'd1,
        MSG_NO_CARD       = 5'd2,
        MSG_FS_STARTED    = 5'd3,
        MSG_OPEN_FAIL     = 5'd4,
        MSG_IMAGE_OPEN    = 5'd5,
        MSG_HDR_READ_FAIL = 5'd6,
        MSG_BAD_TYPE      = 5'd7,
        MSG_BAD_VERSION   = 5'd8,
        MSG_CLOSING_DOOR  = 5'd9,
        MSG_READING       = 5'd10,
        MSG_READ_FAIL     = 5'd11,
        MSG_READ_OK       = 5'd12,
        MSG_CLOSE_FAIL    = 5'd13,
        MSG_WOPEN_FAIL    = 5'd14,
        MSG_WOPEN_OK      = 5'd15,
        MSG_HDR_WR_FAIL   = 5'd16,
        MSG_WRITING       = 5'd17,
        MSG_WRITE_FAIL    = 5'd18,
        MSG_WCLOSE_FAIL   = 5'd19,
        MSG_OPENING_DOOR  = 5'd20,
        MSG_DOOR_OPEN     = 5'd21
    } msg_t;

    // Door actuator commands
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_OPEN  = 2'd2
    } door_cmd_t;

    // Door status codes (anything else reads as moving)
    localparam logic [1:0] DOOR_OPEN   = 2'd1;
    localparam logic [1:0] DOOR_CLOSED = 2'd2;

    // Header check codes
    localparam logic [1:0] HDR_OK          = 2'd0;
    localparam logic [1:0] HDR_BAD_TYPE    = 2'd2;
    localparam logic [1:0] HDR_BAD_VERSION = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_LOAD_ON    = 2'd0;
    localparam logic [1:0] CFG_LOAD_OFF   = 2'd1;
    localparam logic [1:0] CFG_UNLOAD_ON  = 2'd2;
    localparam logic [1:0] CFG_UNLOAD_OFF = 2'd3;

    // Configuration reset values
    localparam logic [7:0] LOAD_FLASH_TICKS   = 8'd7;
    localparam logic [7:0] UNLOAD_FLASH_TICKS = 8'd4;

endpackage

`default_nettype wire

### design/disk_load_unload_sequencer.sv
// The result of an input transfer is registered and shows on m_tdata in the next cycle.
// Throughput: one tick per cycle while m_tready drains the result; the state update and result encode are one
// level of next-state logic plus an 8-bit countdown decrement.
// s_tready stays high while the result register is empty or being drained.
// Reset (aresetn low, synchronous): unloaded idle, lamps and marks cleared,
// countdown zero, flash times back to 7/7 (load) and 4/4 (unload) ticks.
`default_nettype none

module disk_load_unload_sequencer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    // input ticks
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // run_switch[0], protect_switch[1], card_present[2], op_ok[3],
    // header_status[5:4], door_status[7:6]
    input  wire logic [7:0]  s_tdata,
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // state_code[4:0], file_ready_flag[5], ready_lamp_on[6], fault_lamp_on[7],
    // load_lamp_on[8], card_led_on[9], door_command[11:10],
    // close_file_pulse[12], message_code[17:13], zero[23:18]
    output logic [23:0]      m_tdata
);

    // configuration registers
    logic [7:0] load_on_reg, load_off_reg, unload_on_reg, unload_off_reg;

    // sequencer state
    dlus_pkg::state_t state_reg, state_next;
    logic [7:0]       cnt_reg, cnt_next;
    logic             frm_reg, frm_next;
    logic             rdy_reg, rdy_next;
    logic             flt_reg, flt_next;
    logic             ld_reg, ld_next;
    logic             led_reg, led_next;

    // per-tick outputs
    dlus_pkg::door_cmd_t cmd;
    dlus_pkg::msg_t      msg;
    logic                pulse;

    // result register
    logic        m_valid_reg;
    logic [23:0] m_data_reg, m_data_next;

    // unpack input fields
    logic       run, prot, card, ok;
    logic [1:0] hdr, door;
    logic       accept;
    logic [7:0] cnt_dec;
    logic       cnt_expired;

    assign run  = s_tdata[0];
    assign prot = s_tdata[1];
    assign card = s_tdata[2];
    assign ok   = s_tdata[3];
    assign hdr  = s_tdata[5:4];
    assign door = s_tdata[7:6];

    assign s_tready    = !m_valid_reg || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign cnt_dec     = cnt_reg - 8'd1;
    assign cnt_expired = (cnt_dec == 8'd0);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_on_reg    <= dlus_pkg::LOAD_FLASH_TICKS;
            load_off_reg   <= dlus_pkg::LOAD_FLASH_TICKS;
            unload_on_reg  <= dlus_pkg::UNLOAD_FLASH_TICKS;
            unload_off_reg <= dlus_pkg::UNLOAD_FLASH_TICKS;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dlus_pkg::CFG_LOAD_ON:    load_on_reg    <= cfg_wdata;
                dlus_pkg::CFG_LOAD_OFF:   load_off_reg   <= cfg_wdata;
                dlus_pkg::CFG_UNLOAD_ON:  unload_on_reg  <= cfg_wdata;
                dlus_pkg::CFG_UNLOAD_OFF: unload_off_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // next state and flash countdown
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            dlus_pkg::ST_IDLE: begin
                if (run) begin
                    state_next = prot ? dlus_pkg::ST_QCLOSE : dlus_pkg::ST_CARD;
                end
            end
            dlus_pkg::ST_CARD: begin
                state_next = card ? dlus_pkg::ST_MOUNT : dlus_pkg::ST_LERR;
            end
            dlus_pkg::ST_MOUNT: begin
                state_next = ok ? dlus_pkg::ST_OPEN : dlus_pkg::ST_LERR;
            end
            dlus_pkg::ST_OPEN: begin
                state_next = ok ? dlus_pkg::ST_HEADER : dlus_pkg::ST_LERR;
            end
            dlus_pkg::ST_HEADER: begin
                state_next = (hdr != dlus_pkg::HDR_OK) ? dlus_pkg::ST_LERR
                                                       : dlus_pkg::ST_CLOSEWAIT;
            end
            dlus_pkg::ST_CLOSEWAIT: begin
                if (door == dlus_pkg::DOOR_CLOSED) state_next = dlus_pkg::ST_READ;
            end
            dlus_pkg::ST_READ: begin
                state_next = ok ? dlus_pkg::ST_FCLOSE : dlus_pkg::ST_LERR;
            end
            dlus_pkg::ST_FCLOSE: begin
                state_next = ok ? dlus_pkg::ST_LOADED : dlus_pkg::ST_LERR;
            end
            dlus_pkg::ST_LOADED: begin
                if (!run) begin
                    state_next = prot ? dlus_pkg::ST_QOPEN : dlus_pkg::ST_WOPEN;
                end
            end
            dlus_pkg::ST_WOPEN: begin
                state_next = ok ? dlus_pkg::ST_WHEADER : dlus_pkg::ST_UERR;
            end
            dlus_pkg::ST_WHEADER: begin
                state_next = ok ? dlus_pkg::ST_WDATA : dlus_pkg::ST_UERR;
            end
            dlus_pkg::ST_WDATA: begin
                state_next = ok ? dlus_pkg::ST_WCLOSE : dlus_pkg::ST_UERR;
            end
            dlus_pkg::ST_WCLOSE: begin
                state_next = ok ? dlus_pkg::ST_OPENWAIT : dlus_pkg::ST_UERR;
            end
            dlus_pkg::ST_OPENWAIT: begin
                if (door == dlus_pkg::DOOR_OPEN) state_next = dlus_pkg::ST_IDLE;
            end
            dlus_pkg::ST_LERR: begin
                cnt_next   = load_on_reg;
                state_next = dlus_pkg::ST_LON;
            end
            dlus_pkg::ST_LON, dlus_pkg::ST_LOFF: begin
                // count down, swap phase on expiry; door-only move wins the state
                cnt_next = cnt_dec;
                if (cnt_expired) begin
                    if (state_reg == dlus_pkg::ST_LON) begin
                        cnt_next   = load_off_reg;
                        state_next = dlus_pkg::ST_LOFF;
                    end else begin
                        cnt_next   = load_on_reg;
                        state_next = dlus_pkg::ST_LON;
                    end
                end
                if (!run && prot) state_next = dlus_pkg::ST_QOPEN;
            end
            dlus_pkg::ST_QOPEN: begin
                if (door == dlus_pkg::DOOR_OPEN) state_next = dlus_pkg::ST_IDLE;
            end
            dlus_pkg::ST_UERR: begin
                cnt_next   = unload_on_reg;
                state_next = dlus_pkg::ST_UON;
            end
            dlus_pkg::ST_UON, dlus_pkg::ST_UOFF: begin
                cnt_next = cnt_dec;
                if (cnt_expired) begin
                    if (state_reg == dlus_pkg::ST_UON) begin
                        cnt_next   = unload_off_reg;
                        state_next = dlus_pkg::ST_UOFF;
                    end else begin
                        cnt_next   = unload_on_reg;
                        state_next = dlus_pkg::ST_UON;
                    end
                end
                if (run && prot) state_next = dlus_pkg::ST_QCLOSE;
            end
            dlus_pkg::ST_QCLOSE: begin
                if (door == dlus_pkg::DOOR_CLOSED) state_next = dlus_pkg::ST_LOADED;
            end
            default: ;
        endcase
    end

    // lamps, marks, door command, close pulse and message
    always_comb begin
        frm_next = frm_reg;
        rdy_next = rdy_reg;
        flt_next = flt_reg;
        ld_next  = ld_reg;
        led_next = led_reg;
        cmd      = dlus_pkg::CMD_NONE;
        pulse    = 1'b0;
        msg      = dlus_pkg::MSG_NONE;
        case (state_reg)
            dlus_pkg::ST_IDLE: begin
                led_next = 1'b0;
                if (run && prot) begin
                    cmd      = dlus_pkg::CMD_CLOSE;
                    frm_next = 1'b1;
                    rdy_next = 1'b1;
                    ld_next  = 1'b0;
                end
            end
            dlus_pkg::ST_CARD: begin
                led_next = 1'b1;
                msg = card ? dlus_pkg::MSG_CARD_FOUND : dlus_pkg::MSG_NO_CARD;
            end
            dlus_pkg::ST_MOUNT: begin
                if (ok) msg = dlus_pkg::MSG_FS_STARTED;
            end
            dlus_pkg::ST_OPEN: begin
                msg = ok ? dlus_pkg::MSG_IMAGE_OPEN : dlus_pkg::MSG_OPEN_FAIL;
            end
            dlus_pkg::ST_HEADER: begin
                if (hdr != dlus_pkg::HDR_OK) begin
                    pulse = 1'b1;
                    if (hdr == dlus_pkg::HDR_BAD_TYPE) begin
                        msg = dlus_pkg::MSG_BAD_TYPE;
                    end else if (hdr == dlus_pkg::HDR_BAD_VERSION) begin
                        msg = dlus_pkg::MSG_BAD_VERSION;
                    end else begin
                        msg = dlus_pkg::MSG_HDR_READ_FAIL;
                    end
                end else begin
                    ld_next = 1'b0;
                    cmd     = dlus_pkg::CMD_CLOSE;
                    msg     = dlus_pkg::MSG_CLOSING_DOOR;
                end
            end
            dlus_pkg::ST_CLOSEWAIT: begin
                if (door == dlus_pkg::DOOR_CLOSED) msg = dlus_pkg::MSG_READING;
            end
            dlus_pkg::ST_READ: begin
                if (ok) begin
                    msg = dlus_pkg::MSG_READ_OK;
                end else begin
                    pulse = 1'b1;
                    msg   = dlus_pkg::MSG_READ_FAIL;
                end
            end
            dlus_pkg::ST_FCLOSE: begin
                if (ok) begin
                    rdy_next = 1'b1;
                    frm_next = 1'b1;
                end else begin
                    msg = dlus_pkg::MSG_CLOSE_FAIL;
                end
            end
            dlus_pkg::ST_LOADED: begin
                led_next = 1'b1;
                if (!run && prot) begin
                    cmd      = dlus_pkg::CMD_OPEN;
                    frm_next = 1'b0;
                    rdy_next = 1'b0;
                    ld_next  = 1'b1;
                end
            end
            dlus_pkg::ST_WOPEN: begin
                if (ok) begin
                    rdy_next = 1'b0;
                    frm_next = 1'b0;
                    msg      = dlus_pkg::MSG_WOPEN_OK;
                end else begin
                    msg = dlus_pkg::MSG_WOPEN_FAIL;
                end
            end
            dlus_pkg::ST_WHEADER: begin
                if (ok) begin
                    msg = dlus_pkg::MSG_WRITING;
                end else begin
                    pulse = 1'b1;
                    msg   = dlus_pkg::MSG_HDR_WR_FAIL;
                end
            end
            dlus_pkg::ST_WDATA: begin
                if (!ok) begin
                    pulse = 1'b1;
                    msg   = dlus_pkg::MSG_WRITE_FAIL;
                end
            end
            dlus_pkg::ST_WCLOSE: begin
                if (ok) begin
                    msg = dlus_pkg::MSG_OPENING_DOOR;
                    cmd = dlus_pkg::CMD_OPEN;
                end else begin
                    msg = dlus_pkg::MSG_WCLOSE_FAIL;
                end
            end
            dlus_pkg::ST_OPENWAIT: begin
                led_next = 1'b0;
                if (door == dlus_pkg::DOOR_OPEN) begin
                    msg     = dlus_pkg::MSG_DOOR_OPEN;
                    ld_next = 1'b1;
                end
            end
            dlus_pkg::ST_LERR: begin
                led_next = 1'b0;
                flt_next = 1'b1;
            end
            dlus_pkg::ST_LON, dlus_pkg::ST_LOFF: begin
                if (cnt_expired) flt_next = (state_reg == dlus_pkg::ST_LOFF);
                if (!run && prot) begin
                    cmd      = dlus_pkg::CMD_OPEN;
                    flt_next = 1'b0;
                    frm_next = 1'b0;
                    rdy_next = 1'b0;
                    ld_next  = 1'b1;
                end
            end
            dlus_pkg::ST_UERR: begin
                flt_next = 1'b1;
            end
            dlus_pkg::ST_UON, dlus_pkg::ST_UOFF: begin
                if (cnt_expired) flt_next = (state_reg == dlus_pkg::ST_UOFF);
                if (run && prot) begin
                    cmd      = dlus_pkg::CMD_CLOSE;
                    flt_next = 1'b0;
                    frm_next = 1'b1;
                    rdy_next = 1'b1;
                    ld_next  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // pack the result
    assign m_data_next = {6'd0, msg, pulse, cmd, led_next, ld_next, flt_next,
                          rdy_next, frm_next, state_next};

    // advance state on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dlus_pkg::ST_IDLE;
            cnt_reg   <= 8'd0;
            frm_reg   <= 1'b0;
            rdy_reg   <= 1'b0;
            flt_reg   <= 1'b0;
            ld_reg    <= 1'b0;
            led_reg   <= 1'b0;
        end else if (accept) begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            frm_reg   <= frm_next;
            rdy_reg   <= rdy_next;
            flt_reg   <= flt_next;
            ld_reg    <= ld_next;
            led_reg   <= led_next;
        end
    end

    // result register: load on input transfer, drop on output transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire
